### hdl/fdp_pkg.sv
// Shared codes, character constants, sequencer states and digit helper for the format printer.
`timescale 1ns / 1ps

package fdp_pkg;

  localparam logic [2:0] ST_CHAR     = 3'd0;
  localparam logic [2:0] ST_END      = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_NULL_PCT = 3'd3;
  localparam logic [2:0] ST_STRING   = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ONE   = 7'b0000010,
    S_MINUS = 7'b0000100,
    S_CONV  = 7'b0001000,
    S_HEX0  = 7'b0010000,
    S_HEXX  = 7'b0100000,
    S_DIG   = 7'b1000000
  } state_e;

  function automatic logic [7:0] digit_char(logic [3:0] nib);
    logic [7:0] ch;
    if (nib >= 4'hA) begin
      ch = CH_A + {4'h0, nib} - 8'd10;
    end else begin
      ch = CH_ZERO + {4'h0, nib};
    end
    return ch;
  endfunction

endpackage

### hdl/fdp_dabble.sv
// Bit-serial binary to BCD converter: one shift-and-adjust step per cycle.
`timescale 1ns / 1ps

module fdp_dabble #(
  parameter int ARG_WIDTH = 32,
  parameter int DIGITS    = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ARG_WIDTH-1:0]   mag_i,
  output logic                   done_o,
  output logic [DIGITS*4-1:0]    bcd_o
);

  localparam int CW = $clog2(ARG_WIDTH + 1);
  localparam int BW = DIGITS * 4;

  logic [CW-1:0]        cnt_q;
  logic [ARG_WIDTH-1:0] bin_q;
  logic [BW-1:0]        bcd_q;
  logic [BW-1:0]        bcd_adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(ARG_WIDTH);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= mag_i;
      bcd_q <= '0;
    end else if (cnt_q != '0) begin
      bcd_q <= {bcd_adj[BW-2:0], bin_q[ARG_WIDTH-1]};
      bin_q <= {bin_q[ARG_WIDTH-2:0], 1'b0};
    end
  end

  assign done_o = (cnt_q == '0);
  assign bcd_o  = bcd_q;

endmodule

### hdl/format_directive_printer_unit.sv
// Top level of the format directive printer: input decode, sequencer, digit emitter, output register.
// A plain byte, '%%', '%c' or an error is accepted into S_ONE and loaded into the output register from there.
// '%d': serial BCD conversion starts at accept (a minus sign goes out meanwhile), then leading zero
// digits are skipped and one character goes out per digit; '%x': "0x", then the nibbles, leading zeros skipped.
// Throughput: one item at a time; input is ready again once its last result is registered.
// Reset clears the pending-percent flag, the sequencer and the output valid flag.
`timescale 1ns / 1ps

module format_directive_printer_unit #(
  parameter int ARG_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // fmt_char [7:0], arg_value [39:8]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_char [7:0]
  output logic [2:0]  m_axis_tuser_o,   // status [2:0]
  output logic        m_axis_tlast_o
);

  import fdp_pkg::*;

  localparam int DEC_DIGITS = (ARG_WIDTH * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (ARG_WIDTH + 3) / 4;
  localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DGW        = NDIG * 4;
  localparam int HXW        = HEX_DIGITS * 4;
  localparam int DCW        = DEC_DIGITS * 4;
  localparam int CNTW       = $clog2(NDIG + 1);

  logic [7:0]           fmt_char;
  logic [31:0]          arg_in;
  logic [ARG_WIDTH-1:0] arg_ext;
  logic [ARG_WIDTH-1:0] mag;
  logic                 neg;
  logic                 acc;
  logic                 out_free;

  state_e               state_q, state_d;
  logic                 pend_q, pend_d;
  logic [DGW-1:0]       dig_q, dig_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic                 started_q, started_d;
  logic [7:0]           one_char_q, one_char_d;
  logic [2:0]           one_stat_q, one_stat_d;

  logic                 load_out;
  logic [7:0]           o_char;
  logic [2:0]           o_stat;
  logic                 o_last;
  logic                 m_valid_q;
  logic [3:0]           nib;

  logic                 conv_start;
  logic                 conv_done;
  logic [DCW-1:0]       bcd;

  assign fmt_char = s_axis_tdata_i[7:0];
  assign arg_in   = s_axis_tdata_i[39:8];

  generate
    if (ARG_WIDTH <= 32) begin : g_narrow
      assign arg_ext = arg_in[ARG_WIDTH-1:0];
    end else begin : g_wide
      assign arg_ext = {{(ARG_WIDTH-32){1'b0}}, arg_in};
    end
  endgenerate

  assign neg        = arg_ext[ARG_WIDTH-1];
  assign mag        = neg ? (~arg_ext + ARG_WIDTH'(1)) : arg_ext;
  assign acc        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign conv_start = acc && pend_q && (fmt_char == CH_D);
  assign nib        = dig_q[DGW-1 -: 4];

  fdp_dabble #(
    .ARG_WIDTH (ARG_WIDTH),
    .DIGITS    (DEC_DIGITS)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .mag_i   (mag),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    dig_d      = dig_q;
    cnt_d      = cnt_q;
    started_d  = started_q;
    one_char_d = one_char_q;
    one_stat_d = one_stat_q;
    load_out   = 1'b0;
    o_char     = CH_NUL;
    o_stat     = ST_CHAR;
    o_last     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          started_d  = 1'b0;
          one_char_d = CH_NUL;
          one_stat_d = ST_CHAR;
          if (pend_q) begin
            pend_d = 1'b0;
            unique case (fmt_char)
              CH_PCT: begin
                one_char_d = CH_PCT;
                state_d    = S_ONE;
              end
              CH_C: begin
                one_char_d = arg_in[7:0];
                state_d    = S_ONE;
              end
              CH_D: begin
                state_d = neg ? S_MINUS : S_CONV;
              end
              CH_X: begin
                dig_d   = DGW'(HXW'(arg_ext)) << (DGW - HXW);
                cnt_d   = CNTW'(HEX_DIGITS);
                state_d = S_HEX0;
              end
              CH_NUL: begin
                one_stat_d = ST_NULL_PCT;
                state_d    = S_ONE;
              end
              CH_S: begin
                one_stat_d = ST_STRING;
                state_d    = S_ONE;
              end
              default: begin
                one_stat_d = ST_UNKNOWN;
                state_d    = S_ONE;
              end
            endcase
          end else if (fmt_char == CH_PCT) begin
            pend_d = 1'b1;
          end else if (fmt_char == CH_NUL) begin
            one_stat_d = ST_END;
            state_d    = S_ONE;
          end else begin
            one_char_d = fmt_char;
            state_d    = S_ONE;
          end
        end
      end
      S_ONE: begin
        if (out_free) begin
          load_out = 1'b1;
          o_char   = one_char_q;
          o_stat   = one_stat_q;
          o_last   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_MINUS: begin
        if (out_free) begin
          load_out = 1'b1;
          o_char   = CH_MINUS;
          state_d  = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          dig_d   = DGW'(bcd) << (DGW - DCW);
          cnt_d   = CNTW'(DEC_DIGITS);
          state_d = S_DIG;
        end
      end
      S_HEX0: begin
        if (out_free) begin
          load_out = 1'b1;
          o_char   = CH_ZERO;
          state_d  = S_HEXX;
        end
      end
      S_HEXX: begin
        if (out_free) begin
          load_out = 1'b1;
          o_char   = CH_X;
          state_d  = S_DIG;
        end
      end
      S_DIG: begin
        if (nib == 4'h0 && !started_q && cnt_q != CNTW'(1)) begin
          dig_d = dig_q << 4;
          cnt_d = cnt_q - CNTW'(1);
        end else if (out_free) begin
          load_out  = 1'b1;
          o_char    = digit_char(nib);
          o_last    = (cnt_q == CNTW'(1));
          started_d = 1'b1;
          dig_d     = dig_q << 4;
          cnt_d     = cnt_q - CNTW'(1);
          if (cnt_q == CNTW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pend_q    <= 1'b0;
      started_q <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q      <= dig_d;
    one_char_q <= one_char_d;
    one_stat_q <= one_stat_d;
    if (load_out) begin
      m_axis_tdata_o <= o_char;
      m_axis_tuser_o <= o_stat;
      m_axis_tlast_o <= o_last;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;

  a_lone_pct_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !pend_q && fmt_char == CH_PCT) |=> (pend_q && state_q == S_IDLE))
    else $error("lone percent did not arm the pending flag");

  a_error_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ST_CHAR) |-> (m_axis_tdata_o == CH_NUL && m_axis_tlast_o))
    else $error("status result carries a character or is not last");

  a_dig_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIG) |-> (cnt_q != '0))
    else $error("digit emitter ran out of digits");

  a_conv_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_start |=> (!pend_q && (state_q == S_CONV || state_q == S_MINUS)))
    else $error("decimal directive did not enter conversion");

endmodule

### dv/testbench.sv
// Stream testbench for the format directive printer: queued driver, monitor and scoreboard.
`timescale 1ns / 1ps

module testbench;
  import fdp_pkg::*;

  typedef struct packed {
    logic [7:0]  ch;
    logic [31:0] arg;
  } fmt_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] status;
    logic       last;
  } print_rec_t;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 150;
  localparam int QUIET_TAIL  = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [39:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;
  logic [2:0]  m_user;
  logic        m_last;

  fmt_item_t  format_stream[$];
  print_rec_t expected_chars[$];
  logic       pct_pending = 1'b0;
  bit         stim_loaded = 1'b0;

  int items_sent = 0;
  int chars_seen = 0;
  int errors = 0;
  int n_dec = 0;
  int n_hex = 0;
  int n_err = 0;
  int n_end = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;
  fmt_item_t it;

  format_directive_printer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit tail_phase();
    return stim_loaded && format_stream.size() < QUIET_TAIL;
  endfunction

  function automatic void predict_printout(input logic [7:0] ch, input logic [31:0] arg);
    print_rec_t  recs[$];
    logic [31:0] mag;
    logic [3:0]  digs[0:9];
    logic [3:0]  nib;
    int          nd;
    bit          started;
    if (pct_pending) begin
      pct_pending = 1'b0;
      case (ch)
        CH_PCT: recs.push_back('{CH_PCT, ST_CHAR, 1'b0});
        CH_C:   recs.push_back('{arg[7:0], ST_CHAR, 1'b0});
        CH_D: begin
          n_dec++;
          mag = arg;
          if (arg[31]) begin
            recs.push_back('{CH_MINUS, ST_CHAR, 1'b0});
            mag = ~arg + 32'd1;
          end
          nd = 0;
          do begin
            digs[nd] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            nd++;
          end while (mag != 0);
          for (int i = nd - 1; i >= 0; i--) begin
            recs.push_back('{CH_ZERO + 8'(digs[i]), ST_CHAR, 1'b0});
          end
        end
        CH_X: begin
          n_hex++;
          recs.push_back('{CH_ZERO, ST_CHAR, 1'b0});
          recs.push_back('{CH_X, ST_CHAR, 1'b0});
          started = 1'b0;
          for (int d = 7; d >= 0; d--) begin
            nib = arg[d*4 +: 4];
            if (nib == 4'h0 && !started && d > 0) continue;
            started = 1'b1;
            recs.push_back('{(nib >= 4'hA) ? CH_A + 8'(nib) - 8'd10 : CH_ZERO + 8'(nib),
                             ST_CHAR, 1'b0});
          end
        end
        CH_NUL: begin
          n_err++;
          recs.push_back('{CH_NUL, ST_NULL_PCT, 1'b0});
        end
        CH_S: begin
          n_err++;
          recs.push_back('{CH_NUL, ST_STRING, 1'b0});
        end
        default: begin
          n_err++;
          recs.push_back('{CH_NUL, ST_UNKNOWN, 1'b0});
        end
      endcase
    end else if (ch == CH_PCT) begin
      pct_pending = 1'b1;
    end else if (ch == CH_NUL) begin
      n_end++;
      recs.push_back('{CH_NUL, ST_END, 1'b0});
    end else begin
      recs.push_back('{ch, ST_CHAR, 1'b0});
    end
    foreach (recs[i]) begin
      recs[i].last = (i == recs.size() - 1);
      expected_chars.push_back(recs[i]);
    end
  endfunction

  // Offer queued items; hold while stalled, drop valid during idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= '0;
      send_gap = 0;
    end else begin
      if (s_valid && s_ready) begin
        predict_printout(s_data[7:0], s_data[39:8]);
        items_sent++;
      end
      if (!s_valid || s_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_valid <= 1'b0;
        end else if (format_stream.size() == 0) begin
          s_valid <= 1'b0;
        end else if (!tail_phase() && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 2);
          s_valid <= 1'b0;
        end else begin
          it = format_stream.pop_front();
          s_valid <= 1'b1;
          s_data <= {it.arg, it.ch};
        end
      end
    end
  end

  // Receiver readiness: random short stalls plus one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (!hold_done && items_sent >= 60) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_ready <= 1'b0;
      end else if (!tail_phase() && $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(0, 2);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Compare each output item against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected item char=%h status=%0d last=%b",
                 $time, m_data, m_user, m_last);
      end else begin
        if (m_data !== expected_chars[0].ch) begin
          errors++;
          $display("%0t: out_char expected %h actual %h", $time, expected_chars[0].ch, m_data);
        end
        if (m_user !== expected_chars[0].status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d",
                   $time, expected_chars[0].status, m_user);
        end
        if (m_last !== expected_chars[0].last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, expected_chars[0].last, m_last);
        end
        void'(expected_chars.pop_front());
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout with %0d items still expected", $time, expected_chars.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_arg();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, 31);
      2: v = -($urandom >> $urandom_range(0, 31));
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'h0000_0000;
          1: v = 32'h8000_0000;
          2: v = 32'h7fff_ffff;
          default: v = 32'hffff_ffff;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_item(input logic [7:0] ch, input logic [31:0] arg);
    format_stream.push_back('{ch, arg});
  endtask

  task automatic add_directive(input logic [7:0] ch, input logic [31:0] arg);
    add_item(CH_PCT, $urandom);
    add_item(ch, arg);
  endtask

  initial begin
    int          sel;
    logic [7:0]  c;
    add_item(8'h01, 32'h0);
    add_item(8'hff, 32'hffff_ffff);
    add_item(CH_NUL, $urandom);
    add_directive(CH_PCT, 32'h0);
    add_directive(CH_C, 32'hffff_ffff);
    add_directive(CH_D, 32'h8000_0000);
    add_directive(CH_D, 32'h7fff_ffff);
    add_directive(CH_D, 32'h0);
    add_directive(CH_X, 32'h0);
    add_directive(CH_X, 32'hffff_ffff);
    add_directive(CH_S, 32'h1234_5678);
    add_directive(CH_NUL, 32'h0);
    add_directive(8'h71, 32'h0);
    add_item(CH_NUL, 32'h0);
    add_item(CH_NUL, 32'hffff_ffff);

    while (format_stream.size() < 220) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_PCT);
        add_item(c, $urandom);
      end else if (sel < 75) begin
        case ($urandom_range(0, 5))
          0: add_directive(CH_PCT, pick_arg());
          1: add_directive(CH_C, pick_arg());
          2, 3: add_directive(CH_D, pick_arg());
          default: add_directive(CH_X, pick_arg());
        endcase
      end else if (sel < 81) begin
        add_directive(CH_S, pick_arg());
      end else if (sel < 86) begin
        add_directive(CH_NUL, pick_arg());
      end else if (sel < 93) begin
        do c = 8'($urandom_range(1, 255));
        while (c == CH_PCT || c == CH_C || c == CH_D || c == CH_X || c == CH_S);
        add_directive(c, pick_arg());
      end else begin
        add_item(CH_NUL, $urandom);
      end
    end
    stim_loaded = 1'b1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (format_stream.size() != 0 || s_valid) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    $display("Run covered %0d format bytes and %0d output items: %0d decimal, %0d hex,",
             items_sent, chars_seen, n_dec, n_hex);
    $display("%0d error directives, %0d end markers, one long output hold-off; %0d mismatches.",
             n_err, n_end, errors);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
hdl/fdp_pkg.sv
hdl/fdp_dabble.sv
hdl/format_directive_printer_unit.sv
dv/testbench.sv
